/* sv/ntx_pkg.sv */
// ----------------------------------------------------------------------------
// Top-N extrema tracker package
// Shared sizes, the stored entry record, input kind codes, register offsets
// and the per-cell control record.
// ----------------------------------------------------------------------------
package ntx_pkg;

  // Number of cells in the ranked chain.
  localparam int DEPTH = 16;

  // Width of a count that can hold DEPTH itself; the capacity register is
  // 5 bits, so counts and capacities are compared at the wider of the two.
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CW    = (CNT_W > 5) ? CNT_W : 5;

  localparam int CAP_W  = 5;
  localparam int RANK_W = 4;
  localparam int HELD_W = 5;
  localparam int DATA_W = 32;

  localparam logic [CW-1:0] DEPTH_CW = CW'(DEPTH);

  // Values of address bit 2 that select the configuration registers (byte offsets 0 and 4).
  localparam logic REG_FIND_MAXIMA = 1'b0;
  localparam logic REG_CAPACITY    = 1'b1;

  typedef enum logic {
    KIND_ADD  = 1'b0,
    KIND_READ = 1'b1
  } ntx_kind_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] weight;
    logic        [DATA_W-1:0] location;
  } ntx_entry_t;

  // Position of one cell relative to the current fill and capacity.
  typedef struct packed {
    logic occupied;  // cell index is below the entry count
    logic at_end;    // cell index equals the entry count
    logic in_cap;    // cell index is below the effective capacity
  } ntx_cell_ctl_t;

endpackage

/* sv/ntx_cell.sv */
// ----------------------------------------------------------------------------
// Top-N extrema tracker cell
// Holds one ranked entry, compares it against the incoming sample and either
// keeps it, takes the new sample, or takes its upper neighbor's entry.
// ----------------------------------------------------------------------------
module ntx_cell import ntx_pkg::*; (
  input  logic          clk,
  input  logic          add_en,
  input  logic          find_maxima,
  input  ntx_entry_t    new_entry,
  input  ntx_entry_t    prev_entry,
  input  ntx_cell_ctl_t ctl,
  input  logic          prior_in,
  output logic          prior_out,
  output ntx_entry_t    entry
);

  ntx_entry_t entry_r;
  ntx_entry_t entry_nxt;
  logic       beat;
  logic       load;
  logic       shift;

  assign beat = ctl.occupied &&
                (find_maxima ? (new_entry.value > entry_r.value)
                             : (new_entry.value < entry_r.value));

  // The first cell that the sample strictly beats, else the cell at the end of
  // the list, takes it; every cell below it within the capacity moves one rank down.
  assign prior_out = prior_in | beat;
  assign load      = add_en && ctl.in_cap && !prior_in && (beat || ctl.at_end);
  assign shift     = add_en && ctl.in_cap && prior_in && (ctl.occupied || ctl.at_end);

  always_comb begin
    priority if (load) begin
      entry_nxt = new_entry;
    end else if (shift) begin
      entry_nxt = prev_entry;
    end else begin
      entry_nxt = entry_r;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

/* sv/top_n_extrema_tracker_unit.sv */
// ----------------------------------------------------------------------------
// Top-N extrema tracker
// Keeps the most extreme samples in rank order in a chain of compare cells.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while its input is not
// stalled and gives its result from an output register; an add is settled
// combinationally by a ripple of compare cells across all DEPTH ranks, which
// sets the longest path. A read returns the entry held at the requested rank
// (rank 0 is the best) and the count held; an add returns the count after the
// insertion. The output register stalls the input only while a result waits.
module top_n_extrema_tracker_unit import ntx_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  // Configuration port.
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [2:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  // Input channel.
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_kind,
  input  logic signed [DATA_W-1:0] in_sample_value,
  input  logic signed [DATA_W-1:0] in_sample_weight,
  input  logic        [DATA_W-1:0] in_case_location,
  input  logic                     in_is_missing,
  input  logic        [RANK_W-1:0] in_rank,
  // Result channel.
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_present,
  output logic signed [DATA_W-1:0] out_entry_value,
  output logic signed [DATA_W-1:0] out_entry_weight,
  output logic        [DATA_W-1:0] out_entry_location,
  output logic        [HELD_W-1:0] out_held
);

  logic              find_maxima_r;
  logic [CAP_W-1:0]  capacity_r;
  logic [CW-1:0]     count_r;
  logic [CW-1:0]     count_nxt;
  logic [CW-1:0]     cap_ext;
  logic [CW-1:0]     eff_cap;
  logic [CW:0]       count_inc;
  logic              cfg_wr;
  logic              accept;
  logic              add_en;
  logic              is_read;
  logic              present;
  ntx_entry_t        new_entry;
  ntx_entry_t        rd_entry;
  ntx_entry_t        cell_entry [DEPTH];
  ntx_cell_ctl_t     cell_ctl   [DEPTH];
  logic [DEPTH:0]    prior;

  logic                     out_valid_r;
  logic                     out_present_r;
  ntx_entry_t               out_entry_r;
  logic [HELD_W-1:0]        out_held_r;

  // Configuration registers.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      find_maxima_r <= 1'b1;
      capacity_r    <= CAP_W'(16);
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_FIND_MAXIMA: find_maxima_r <= pwdata[0];
        REG_CAPACITY:    capacity_r    <= pwdata[CAP_W-1:0];
        default:         find_maxima_r <= find_maxima_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FIND_MAXIMA: prdata = {31'd0, find_maxima_r};
      REG_CAPACITY:    prdata = {{(32-CAP_W){1'b0}}, capacity_r};
      default:         prdata = '0;
    endcase
  end

  // A capacity of zero acts as one, and anything past the chain length as
  // the chain length.
  assign cap_ext = CW'(capacity_r);
  always_comb begin
    priority if (cap_ext == '0) begin
      eff_cap = CW'(1);
    end else if (cap_ext > DEPTH_CW) begin
      eff_cap = DEPTH_CW;
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Handshake.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_read  = (ntx_kind_t'(in_kind) == KIND_READ);
  assign add_en   = accept && !is_read && !in_is_missing;

  assign new_entry.value    = in_sample_value;
  assign new_entry.weight   = in_sample_weight;
  assign new_entry.location = in_case_location;

  // Cell chain.
  assign prior[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign cell_ctl[i].occupied = (CW'(i) < count_r);
    assign cell_ctl[i].at_end   = (CW'(i) == count_r);
    assign cell_ctl[i].in_cap   = (CW'(i) < eff_cap);

    ntx_cell u_cell (
      .clk         (clk),
      .add_en      (add_en),
      .find_maxima (find_maxima_r),
      .new_entry   (new_entry),
      .prev_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i-1]),
      .ctl         (cell_ctl[i]),
      .prior_in    (prior[i]),
      .prior_out   (prior[i+1]),
      .entry       (cell_entry[i])
    );
  end

  // Entry count after an add saturates at the capacity, which also trims a
  // list left longer by a lowered capacity.
  assign count_inc = {1'b0, count_r} + (CW+1)'(1);
  assign count_nxt = (count_inc < {1'b0, eff_cap}) ? count_inc[CW-1:0] : eff_cap;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (add_en) begin
      count_r <= count_nxt;
    end
  end

  // Rank read.
  assign present = is_read && (CW'(in_rank) < count_r);

  always_comb begin
    rd_entry = '0;
    for (int j = 0; j < DEPTH; j++) begin
      if (CW'(in_rank) == CW'(j)) begin
        rd_entry = cell_entry[j];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_present_r <= present;
      out_entry_r   <= present ? rd_entry : '0;
      out_held_r    <= add_en ? count_nxt[HELD_W-1:0] : count_r[HELD_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_present        = out_present_r;
  assign out_entry_value    = out_entry_r.value;
  assign out_entry_weight   = out_entry_r.weight;
  assign out_entry_location = out_entry_r.location;
  assign out_held           = out_held_r;

endmodule

/* bench/tb_top_n_extrema_tracker_unit.sv */
// ----------------------------------------------------------------------------
// Top-N extrema tracker testbench
// Drives add and read transactions through the valid/stall input channel,
// predicts every result with an independent ranked-list model and checks
// each result field by field. Direction and capacity are rewritten between
// phases over the APB port, and both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top_n_extrema_tracker_unit;
  import ntx_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 163;

  typedef struct packed {
    ntx_kind_t                kind;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] weight;
    logic        [DATA_W-1:0] location;
    logic                     missing;
    logic        [RANK_W-1:0] rank;
  } sample_t;

  typedef struct packed {
    logic                     present;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] weight;
    logic        [DATA_W-1:0] location;
    logic        [HELD_W-1:0] held;
  } rank_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     in_kind = 1'b0;
  logic signed [DATA_W-1:0] in_sample_value = '0;
  logic signed [DATA_W-1:0] in_sample_weight = '0;
  logic        [DATA_W-1:0] in_case_location = '0;
  logic                     in_is_missing = 1'b0;
  logic        [RANK_W-1:0] in_rank = '0;

  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic                     out_present;
  logic signed [DATA_W-1:0] out_entry_value;
  logic signed [DATA_W-1:0] out_entry_weight;
  logic        [DATA_W-1:0] out_entry_location;
  logic        [HELD_W-1:0] out_held;

  top_n_extrema_tracker_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_kind            (in_kind),
    .in_sample_value    (in_sample_value),
    .in_sample_weight   (in_sample_weight),
    .in_case_location   (in_case_location),
    .in_is_missing      (in_is_missing),
    .in_rank            (in_rank),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_present        (out_present),
    .out_entry_value    (out_entry_value),
    .out_entry_weight   (out_entry_weight),
    .out_entry_location (out_entry_location),
    .out_held           (out_held)
  );

  always #5 clk = ~clk;

  // Ranked-list model state and its copy of the registers.
  logic signed [DATA_W-1:0] ranked_val [DEPTH];
  logic signed [DATA_W-1:0] ranked_wgt [DEPTH];
  logic        [DATA_W-1:0] ranked_loc [DEPTH];
  int unsigned              held_count = 0;
  logic                     keep_largest = 1'b1;
  logic        [CAP_W-1:0]  cap_setting = 5'd16;

  sample_t      sample_q [$];
  rank_result_t ranked_expect_q [$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_cnt = 0;
  int results_seen = 0;
  int items_sent = 0;
  int adds_taken = 0;
  int reads_taken = 0;
  int cycle_cnt = 0;
  sample_t cur_sample = '0;

  task automatic predict_ranked(input sample_t s, output rank_result_t r);
    int unsigned cap;
    int unsigned pos;
    int unsigned top;
    bit          found;
    int          i;
    r = '0;
    found = 1'b0;
    if (s.kind == KIND_ADD) begin
      if (!s.missing) begin
        cap = (cap_setting == 0) ? 1 : ((cap_setting > DEPTH) ? DEPTH : cap_setting);
        pos = held_count;
        for (i = 0; i < int'(held_count); i++) begin
          if (!found && (keep_largest ? (s.value > ranked_val[i])
                                      : (s.value < ranked_val[i]))) begin
            pos = i;
            found = 1'b1;
          end
        end
        if (pos < cap) begin
          top = (held_count < cap - 1) ? held_count : cap - 1;
          for (i = int'(top); i > int'(pos); i--) begin
            ranked_val[i] = ranked_val[i-1];
            ranked_wgt[i] = ranked_wgt[i-1];
            ranked_loc[i] = ranked_loc[i-1];
          end
          ranked_val[pos] = s.value;
          ranked_wgt[pos] = s.weight;
          ranked_loc[pos] = s.location;
        end
        held_count = (held_count + 1 < cap) ? held_count + 1 : cap;
      end
    end else if (s.rank < held_count) begin
      r.present  = 1'b1;
      r.value    = ranked_val[s.rank];
      r.weight   = ranked_wgt[s.rank];
      r.location = ranked_loc[s.rank];
    end
    r.held = HELD_W'(held_count);
  endtask

  // Driver: presents queued samples, holds them while stalled.
  always @(posedge clk) begin
    rank_result_t r;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_ranked(cur_sample, r);
        ranked_expect_q.push_back(r);
        if (cur_sample.kind == KIND_ADD) adds_taken++;
        else reads_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_sample       <= sample_q[0];
          in_kind          <= sample_q[0].kind;
          in_sample_value  <= sample_q[0].value;
          in_sample_weight <= sample_q[0].weight;
          in_case_location <= sample_q[0].location;
          in_is_missing    <= sample_q[0].missing;
          in_rank          <= sample_q[0].rank;
          in_valid         <= 1'b1;
          void'(sample_q.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random back-pressure and the result check.
  always @(posedge clk) begin
    rank_result_t e;
    bit           bad;
    if (rst_n) begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
      if (out_valid && !out_stall) begin
        results_seen++;
        if (ranked_expect_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("ERROR: result with no transaction pending: held=%0d", out_held);
        end else begin
          e = ranked_expect_q.pop_front();
          bad = (out_present !== e.present) || (out_entry_value !== e.value) ||
                (out_entry_weight !== e.weight) ||
                (out_entry_location !== e.location) || (out_held !== e.held);
          if (bad) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display({"ERROR: result %0d exp p=%0b v=%h w=%h l=%h n=%0d",
                        " got p=%0b v=%h w=%h l=%h n=%0d"},
                       results_seen, e.present, e.value, e.weight, e.location, e.held,
                       out_present, out_entry_value, out_entry_weight,
                       out_entry_location, out_held);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic push_sample(input ntx_kind_t kind, input logic [31:0] value,
                             input logic [31:0] weight, input logic [31:0] location,
                             input logic missing, input logic [RANK_W-1:0] rank);
    sample_t s;
    s.kind = kind;
    s.value = value;
    s.weight = weight;
    s.location = location;
    s.missing = missing;
    s.rank = rank;
    sample_q.push_back(s);
    items_sent++;
  endtask

  task automatic apb_write(input logic addr_sel, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {addr_sel, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr_sel == REG_FIND_MAXIMA) keep_largest = data[0];
    else cap_setting = data[CAP_W-1:0];
  endtask

  // Waits until every transaction has been sent and answered.
  task automatic wait_quiet();
    do @(negedge clk);
    while (sample_q.size() != 0 || in_valid || ranked_expect_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_value();
    int v;
    case ($urandom_range(4))
      0, 1: pick_value = $urandom();
      2: begin
        // Narrow spread so that ties are common.
        v = int'($urandom_range(8)) - 4;
        pick_value = v << 16;
      end
      3: case ($urandom_range(4))
        0: pick_value = 32'h7fff_ffff;
        1: pick_value = 32'h8000_0000;
        2: pick_value = 32'h0000_0000;
        3: pick_value = 32'hffff_ffff;
        default: pick_value = 32'h0000_0001;
      endcase
      default: pick_value = $urandom_range(2000) - 1000;
    endcase
  endfunction

  task automatic push_random(input int n);
    int p;
    for (int k = 0; k < n; k++) begin
      p = $urandom_range(99);
      if (p < 55)
        push_sample(KIND_ADD, pick_value(), $urandom(), $urandom(),
                    ($urandom_range(99) < 8), RANK_W'($urandom()));
      else if (p < 95)
        push_sample(KIND_READ, $urandom(), $urandom(), $urandom(), 1'($urandom()),
                    RANK_W'($urandom_range(15)));
      else
        push_sample(KIND_ADD, $urandom(), $urandom(), $urandom(), 1'b1,
                    RANK_W'($urandom()));
    end
  endtask

  initial begin
    logic        cfg_max [RAND_PHASES];
    logic [31:0] cfg_cap [RAND_PHASES];
    cfg_max = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    cfg_cap = '{32'd16, 32'd1, 32'd3, 32'd0, 32'd31, 32'd5, 32'd17, 32'd16};

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty read, extremes, ties and a missing sample, reset setup.
    push_sample(KIND_READ, 0, 0, 0, 1'b0, 4'd0);
    push_sample(KIND_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 1'b0, 4'd0);
    push_sample(KIND_ADD, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 1'b0, 4'd15);
    push_sample(KIND_ADD, 32'h1234_0000, 32'hdead_beef, 32'h0000_0005, 1'b1, 4'd0);
    push_sample(KIND_ADD, 32'h0000_0000, 32'h0001_0000, 32'h0000_0007, 1'b0, 4'd0);
    push_sample(KIND_ADD, 32'h0000_0000, 32'hffff_0000, 32'h0000_0008, 1'b0, 4'd0);
    push_sample(KIND_ADD, 32'h7fff_ffff, 32'h0000_0001, 32'h0000_0009, 1'b0, 4'd0);
    for (int k = 0; k < 6; k++)
      push_sample(KIND_READ, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1'b1,
                  RANK_W'(k));
    push_sample(KIND_READ, 0, 0, 0, 1'b0, 4'd15);
    wait_quiet();

    // Capacity lowered below the count, then the direction flipped.
    apb_write(REG_CAPACITY, 32'd2);
    for (int k = 0; k < 4; k++) push_sample(KIND_READ, 0, 0, 0, 1'b0, RANK_W'(k));
    push_sample(KIND_ADD, 32'h0000_8000, 32'h0000_0003, 32'h0000_0042, 1'b0, 4'd0);
    for (int k = 0; k < 3; k++) push_sample(KIND_READ, 0, 0, 0, 1'b0, RANK_W'(k));
    wait_quiet();
    apb_write(REG_FIND_MAXIMA, 32'd0);
    push_sample(KIND_ADD, 32'h0000_4000, 32'h0000_0004, 32'h0000_0043, 1'b0, 4'd0);
    push_sample(KIND_READ, 0, 0, 0, 1'b0, 4'd0);
    push_sample(KIND_READ, 0, 0, 0, 1'b0, 4'd1);
    wait_quiet();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      apb_write(REG_FIND_MAXIMA, {31'd0, cfg_max[ph]});
      apb_write(REG_CAPACITY, cfg_cap[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 34; recv_stall_pct = 34; end
      endcase
      push_random(PHASE_ITEMS);
      wait_quiet();
    end

    $display("Sent %0d transactions (%0d adds, %0d reads), checked %0d results.",
             items_sent, adds_taken, reads_taken, results_seen);
    $display("Covered both directions, capacities 0 to 31 and four idle patterns.");
    if (mismatch_cnt == 0 && ranked_expect_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("FAIL");
    end
    $finish;
  end

endmodule
